### rtl/core/sdyr_pkg.sv
// Shared types and constants for the steady-state yaw rate command block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package sdyr_pkg;

    // Quotient bits produced by the restoring dividers.
    localparam int QW = 24;

    // Datapath widths.
    localparam int NUM_W = 103;   // Ue*|delta|*64000*L*kr*kf
    localparam int DEN_W = 93;    // |L*L*kr*kf*65536 +- 1000*m*diff*Ue*Ue|
    localparam int RN_W  = 33;    // mu*g*128
    localparam int RD_W  = 23;    // 125*Ue
    localparam int CFG_W = 20;    // widest configuration register

    localparam logic [15:0] NUM_SCALE  = 16'd64000;
    localparam logic [9:0]  MASS_SCALE = 10'd1000;
    localparam logic [6:0]  RMAX_SCALE = 7'd125;

    // Cycles the derived-constant pipeline needs after a register write.
    localparam logic [2:0] CFG_SETTLE = 3'd4;

    localparam logic [24:0] POS_LIMIT = 25'h07FFFFF;
    localparam logic [24:0] NEG_LIMIT = 25'h0800000;

    typedef enum logic [2:0] {
        REG_MASS        = 3'd0,
        REG_FRONT_DIST  = 3'd1,
        REG_REAR_DIST   = 3'd2,
        REG_FRONT_STIFF = 3'd3,
        REG_REAR_STIFF  = 3'd4,
        REG_FRICTION    = 3'd5,
        REG_GRAVITY     = 3'd6,
        REG_MIN_SPEED   = 3'd7
    } cfg_reg_t;

    // Constants derived from the configuration registers.
    typedef struct packed {
        logic [14:0] min_speed;
        logic [25:0] m1000;     // 1000*m
        logic        dsign;     // b*kf < a*kr
        logic [33:0] diff;      // |b*kf - a*kr|
        logic [54:0] lkk;       // L*kr*kf
        logic [85:0] t1;        // L*L*kr*kf*65536
        logic [32:0] rnum;      // mu*g*128
    } cfg_derived_t;

    typedef struct packed {
        logic fault;
        logic dneg;
        logic dzero;
        logic den_neg;
    } item_flags_t;

endpackage

### rtl/core/sdyr_cfg.sv
// Configuration registers and the short pipeline that derives the vehicle constants.
// Depends on sdyr_pkg.
`timescale 1ns / 1ps

module sdyr_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [sdyr_pkg::CFG_W-1:0]  cfg_data,
    output sdyr_pkg::cfg_derived_t      derived,
    output logic                        busy
);

    logic [15:0] mass_reg;
    logic [13:0] fdist_reg;
    logic [13:0] rdist_reg;
    logic [19:0] fstiff_reg;
    logic [19:0] rstiff_reg;
    logic [11:0] mu_reg;
    logic [13:0] grav_reg;
    logic [14:0] minspd_reg;
    logic [2:0]  settle_reg;

    logic [14:0] len_reg;
    logic [33:0] bkf_reg;
    logic [33:0] akr_reg;
    logic [39:0] krkf_reg;
    logic [25:0] mg_reg;
    logic [25:0] m1000_reg;
    logic [14:0] lenc_reg;
    logic        dsign_reg;
    logic [33:0] diff_reg;
    logic [54:0] lkk_reg;
    logic [32:0] rnum_reg;
    logic [85:0] t1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= 16'd1500;
            fdist_reg  <= 14'd1200;
            rdist_reg  <= 14'd1500;
            fstiff_reg <= 20'd80000;
            rstiff_reg <= 20'd80000;
            mu_reg     <= 12'd1024;
            grav_reg   <= 14'd9810;
            minspd_reg <= 15'd128;
            settle_reg <= sdyr_pkg::CFG_SETTLE;
        end
        else
        begin
            if (cfg_write)
            begin
                settle_reg <= sdyr_pkg::CFG_SETTLE;
                case (sdyr_pkg::cfg_reg_t'(cfg_index))
                    sdyr_pkg::REG_MASS:        mass_reg   <= cfg_data[15:0];
                    sdyr_pkg::REG_FRONT_DIST:  fdist_reg  <= cfg_data[13:0];
                    sdyr_pkg::REG_REAR_DIST:   rdist_reg  <= cfg_data[13:0];
                    sdyr_pkg::REG_FRONT_STIFF: fstiff_reg <= cfg_data[19:0];
                    sdyr_pkg::REG_REAR_STIFF:  rstiff_reg <= cfg_data[19:0];
                    sdyr_pkg::REG_FRICTION:    mu_reg     <= cfg_data[11:0];
                    sdyr_pkg::REG_GRAVITY:     grav_reg   <= cfg_data[13:0];
                    sdyr_pkg::REG_MIN_SPEED:   minspd_reg <= cfg_data[14:0];
                    default:                   mass_reg   <= mass_reg;
                endcase
            end
            else if (settle_reg != 3'd0)
            begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    // Three register stages; no path into a stage passes through more than one multiplier.
    always_ff @(posedge clk)
    begin
        len_reg   <= {1'b0, fdist_reg} + {1'b0, rdist_reg};
        bkf_reg   <= {20'd0, rdist_reg} * {14'd0, fstiff_reg};
        akr_reg   <= {20'd0, fdist_reg} * {14'd0, rstiff_reg};
        krkf_reg  <= {20'd0, rstiff_reg} * {20'd0, fstiff_reg};
        mg_reg    <= {14'd0, mu_reg} * {12'd0, grav_reg};
        m1000_reg <= {10'd0, mass_reg} * {16'd0, sdyr_pkg::MASS_SCALE};

        lenc_reg  <= len_reg;
        dsign_reg <= bkf_reg < akr_reg;
        diff_reg  <= (bkf_reg >= akr_reg) ? (bkf_reg - akr_reg) : (akr_reg - bkf_reg);
        lkk_reg   <= {40'd0, len_reg} * {15'd0, krkf_reg};
        rnum_reg  <= {mg_reg, 7'd0};

        t1_reg    <= {({55'd0, lenc_reg} * {15'd0, lkk_reg}), 16'd0};
    end

    assign busy = settle_reg != 3'd0;

    assign derived.min_speed = minspd_reg;
    assign derived.m1000     = m1000_reg;
    assign derived.dsign     = dsign_reg;
    assign derived.diff      = diff_reg;
    assign derived.lkk       = lkk_reg;
    assign derived.t1        = t1_reg;
    assign derived.rnum      = rnum_reg;

endmodule

### rtl/core/sdyr_front.sv
// Six-stage front end: magnitudes, speed products, numerator and signed denominator.
// Depends on sdyr_pkg and the derived constants from sdyr_cfg.
`timescale 1ns / 1ps

module sdyr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_take,
    input  logic signed [15:0]           steer_angle,
    input  logic signed [15:0]           speed,
    input  sdyr_pkg::cfg_derived_t       derived,
    output logic                         head_free,
    output logic                         out_valid,
    output logic [sdyr_pkg::NUM_W-1:0]   num,
    output logic [sdyr_pkg::DEN_W-1:0]   den,
    output sdyr_pkg::item_flags_t        flags,
    output logic [sdyr_pkg::RD_W-1:0]    rden,
    output logic                         ue_zero
);

    logic [5:0]  vld_reg;
    logic [15:0] sa;
    logic [15:0] sp;
    logic [15:0] dmag;
    logic [15:0] umag;
    logic [15:0] ue;

    logic [15:0] s1_dmag_reg, s1_ue_reg;
    logic [1:0]  s1_dd_reg, s2_dd_reg, s3_dd_reg, s4_dd_reg, s5_dd_reg;
    logic [31:0] s2_ue2_reg, s2_ud_reg;
    logic [15:0] s2_ue_reg;
    logic [57:0] s3_mu2_reg;
    logic [47:0] s3_nlo_reg;
    logic [22:0] s3_dvr_reg, s4_dvr_reg, s5_dvr_reg, s6_dvr_reg;
    logic        s3_uez_reg, s4_uez_reg, s5_uez_reg, s6_uez_reg;
    logic [62:0] s4_plo_reg, s4_phi_reg;
    logic [51:0] s4_q0_reg, s4_q2_reg;
    logic [50:0] s4_q1_reg, s4_q3_reg;
    logic [91:0] s5_t2_reg;
    logic [102:0] s5_num_reg, s6_num_reg;
    logic [92:0] den_next, s6_den_reg;
    logic        den_neg_next;
    sdyr_pkg::item_flags_t s6_flags_reg;

    assign head_free = en || !vld_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (head_free)
            begin
                vld_reg[0] <= in_take;
            end
            if (en)
            begin
                vld_reg[5:1] <= vld_reg[4:0];
            end
        end
    end

    assign sa   = steer_angle;
    assign sp   = speed;
    assign dmag = sa[15] ? (~sa + 16'd1) : sa;
    assign umag = sp[15] ? (~sp + 16'd1) : sp;
    assign ue   = (umag > {1'b0, derived.min_speed}) ? umag : {1'b0, derived.min_speed};

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            s1_dmag_reg <= dmag;
            s1_ue_reg   <= ue;
            s1_dd_reg   <= {sa[15], dmag == 16'd0};
        end
    end

    always_comb
    begin
        den_neg_next = 1'b0;
        if (!derived.dsign)
        begin
            den_next = {7'd0, derived.t1} + {1'b0, s5_t2_reg};
        end
        else if ({6'd0, derived.t1} >= s5_t2_reg)
        begin
            den_next = {7'd0, derived.t1} - {1'b0, s5_t2_reg};
        end
        else
        begin
            den_next     = {1'b0, s5_t2_reg} - {7'd0, derived.t1};
            den_neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ue2_reg <= {16'd0, s1_ue_reg} * {16'd0, s1_ue_reg};
            s2_ud_reg  <= {16'd0, s1_ue_reg} * {16'd0, s1_dmag_reg};
            s2_ue_reg  <= s1_ue_reg;
            s2_dd_reg  <= s1_dd_reg;

            s3_mu2_reg <= {26'd0, s2_ue2_reg} * {32'd0, derived.m1000};
            s3_nlo_reg <= {16'd0, s2_ud_reg} * {32'd0, sdyr_pkg::NUM_SCALE};
            s3_dvr_reg <= {7'd0, s2_ue_reg} * {16'd0, sdyr_pkg::RMAX_SCALE};
            s3_uez_reg <= s2_ue_reg == 16'd0;
            s3_dd_reg  <= s2_dd_reg;

            s4_plo_reg <= {34'd0, s3_mu2_reg[28:0]} * {29'd0, derived.diff};
            s4_phi_reg <= {34'd0, s3_mu2_reg[57:29]} * {29'd0, derived.diff};
            s4_q0_reg  <= {28'd0, s3_nlo_reg[23:0]} * {24'd0, derived.lkk[27:0]};
            s4_q1_reg  <= {27'd0, s3_nlo_reg[23:0]} * {24'd0, derived.lkk[54:28]};
            s4_q2_reg  <= {28'd0, s3_nlo_reg[47:24]} * {24'd0, derived.lkk[27:0]};
            s4_q3_reg  <= {27'd0, s3_nlo_reg[47:24]} * {24'd0, derived.lkk[54:28]};
            s4_dvr_reg <= s3_dvr_reg;
            s4_uez_reg <= s3_uez_reg;
            s4_dd_reg  <= s3_dd_reg;

            s5_t2_reg  <= {29'd0, s4_plo_reg} + {s4_phi_reg, 29'd0};
            s5_num_reg <= {51'd0, s4_q0_reg} + {24'd0, s4_q1_reg, 28'd0}
                        + {27'd0, s4_q2_reg, 24'd0} + {s4_q3_reg, 52'd0};
            s5_dvr_reg <= s4_dvr_reg;
            s5_uez_reg <= s4_uez_reg;
            s5_dd_reg  <= s4_dd_reg;

            s6_num_reg           <= s5_num_reg;
            s6_den_reg           <= den_next;
            s6_flags_reg.fault   <= den_next == '0;
            s6_flags_reg.dneg    <= s5_dd_reg[1];
            s6_flags_reg.dzero   <= s5_dd_reg[0];
            s6_flags_reg.den_neg <= den_neg_next;
            s6_dvr_reg           <= s5_dvr_reg;
            s6_uez_reg           <= s5_uez_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign num       = s6_num_reg;
    assign den       = s6_den_reg;
    assign flags     = s6_flags_reg;
    assign rden      = s6_dvr_reg;
    assign ue_zero   = s6_uez_reg;

endmodule

### rtl/core/sdyr_div.sv
// Pipelined restoring divider: one overflow check stage, then one quotient bit per stage.
// Depends on sdyr_pkg for the quotient width.
`timescale 1ns / 1ps

module sdyr_div #(
    parameter int NW = 33,
    parameter int DW = 23,
    parameter int SW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [NW-1:0]           n,
    input  logic [DW-1:0]           d,
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic [sdyr_pkg::QW:0]   quot,
    output logic [SW-1:0]           side_out
);

    localparam int QW = sdyr_pkg::QW;
    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW:0]    vld_reg;
    logic [XW-1:0]  rem_reg  [QW];
    logic [DW-1:0]  d_reg    [QW];
    logic [QW-1:0]  q_reg    [QW+1];
    logic           sat_reg  [QW+1];
    logic [SW-1:0]  side_reg [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    // A quotient that would need more than QW bits is flagged and reported as 2^QW.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= XW'(n);
            d_reg[0]    <= d;
            q_reg[0]    <= '0;
            sat_reg[0]  <= XW'(n) >= (XW'(d) << QW);
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int B = QW - j;
        logic [XW-1:0] trial;
        logic          ge;

        assign trial = XW'(d_reg[j-1]) << B;
        assign ge    = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]    <= q_reg[j-1] | (QW'(ge) << B);
                sat_reg[j]  <= sat_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end

        if (j < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                    d_reg[j]   <= d_reg[j-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quot      = sat_reg[QW] ? {1'b1, QW'(0)} : {1'b0, q_reg[QW]};
    assign side_out  = side_reg[QW];

endmodule

### rtl/core/steady_state_yaw_rate_command.sv
// Top level of the steady-state yaw rate command: configuration, front end, two dividers
// and the saturate/clamp output stage. Depends on sdyr_pkg, sdyr_cfg, sdyr_front, sdyr_div.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    steer_angle, speed
// output    out_valid / out_stall  yaw_rate, friction_limited, denom_fault
// config    cfg_write              cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low; each word's result passes six front-end
// stages, 25 divider stages and one output register. The divider stages set the latency.
// After reset and after every register write, in_stall is held high while the derived
// vehicle constants settle through their own three-stage pipeline.
// A stalled output freezes the pipeline; the first stage still takes a word while it is empty.

module steady_state_yaw_rate_command (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [sdyr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [15:0]          steer_angle,
    input  logic signed [15:0]          speed,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [23:0]          yaw_rate,
    output logic                        friction_limited,
    output logic                        denom_fault
);

    sdyr_pkg::cfg_derived_t derived;
    logic                   busy;
    logic                   en;
    logic                   head_free;
    logic                   in_take;

    logic                             fe_valid;
    logic [sdyr_pkg::NUM_W-1:0]       fe_num;
    logic [sdyr_pkg::DEN_W-1:0]       fe_den;
    sdyr_pkg::item_flags_t            fe_flags;
    logic [sdyr_pkg::RD_W-1:0]        fe_rden;
    logic                             fe_uez;

    logic                             div_valid;
    logic [sdyr_pkg::QW:0]            div_quot;
    logic [$bits(sdyr_pkg::item_flags_t)-1:0] div_side;
    logic                             rdiv_valid;
    logic [sdyr_pkg::QW:0]            rdiv_quot;
    logic                             rdiv_uez;

    sdyr_pkg::item_flags_t            fl;
    logic                             neg;
    logic [24:0]                      mag;
    logic [24:0]                      rmax;
    logic signed [25:0]               r;
    logic signed [25:0]               rs;
    logic                             lim;

    logic                             out_valid_reg;
    logic [23:0]                      yaw_reg;
    logic                             lim_reg;
    logic                             fault_reg;

    // The whole pipeline moves unless a finished word is waiting on a stalled output.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = busy || !head_free;
    assign in_take  = in_valid && !in_stall;

    sdyr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived),
        .busy      (busy)
    );

    sdyr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_take     (in_take),
        .steer_angle (steer_angle),
        .speed       (speed),
        .derived     (derived),
        .head_free   (head_free),
        .out_valid   (fe_valid),
        .num         (fe_num),
        .den         (fe_den),
        .flags       (fe_flags),
        .rden        (fe_rden),
        .ue_zero     (fe_uez)
    );

    // Main quotient: trunc(Nn/|Dn|), reported as 2^24 when it overflows 24 bits.
    sdyr_div #(
        .NW (sdyr_pkg::NUM_W),
        .DW (sdyr_pkg::DEN_W),
        .SW ($bits(sdyr_pkg::item_flags_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fe_valid),
        .n         (fe_num),
        .d         (fe_den),
        .side_in   (fe_flags),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    // Friction bound: floor(mu*g*128 / (125*Ue)), running in step with the main divider.
    sdyr_div #(
        .NW (sdyr_pkg::RN_W),
        .DW (sdyr_pkg::RD_W),
        .SW (1)
    ) u_rdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fe_valid),
        .n         (derived.rnum),
        .d         (fe_rden),
        .side_in   (fe_uez),
        .out_valid (rdiv_valid),
        .quot      (rdiv_quot),
        .side_out  (rdiv_uez)
    );

    // Sign and saturation of the quotient, then the friction clamp. A zero denominator
    // gives full scale with the sign of the steering angle, or zero for a zero angle.
    always_comb
    begin
        fl = sdyr_pkg::item_flags_t'(div_side);
        if (fl.fault)
        begin
            neg = fl.dneg;
            if (fl.dzero)
            begin
                mag = '0;
            end
            else
            begin
                mag = neg ? sdyr_pkg::NEG_LIMIT : sdyr_pkg::POS_LIMIT;
            end
        end
        else
        begin
            neg = fl.dneg ^ fl.den_neg;
            if (neg)
            begin
                mag = (div_quot > sdyr_pkg::NEG_LIMIT) ? sdyr_pkg::NEG_LIMIT : div_quot;
            end
            else
            begin
                mag = (div_quot > sdyr_pkg::POS_LIMIT) ? sdyr_pkg::POS_LIMIT : div_quot;
            end
        end

        r    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        rmax = (rdiv_quot > sdyr_pkg::NEG_LIMIT) ? sdyr_pkg::NEG_LIMIT : rdiv_quot;
        rs   = $signed({1'b0, rmax});
        lim  = 1'b0;

        // With a zero effective speed the bound does not apply.
        if (!rdiv_uez)
        begin
            if (r > rs)
            begin
                r   = rs;
                lim = 1'b1;
            end
            else if (r < -rs)
            begin
                r   = -rs;
                lim = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= r[23:0];
            lim_reg   <= lim;
            fault_reg <= fl.fault;
        end
    end

    assign out_valid        = out_valid_reg;
    assign yaw_rate         = yaw_reg;
    assign friction_limited = lim_reg;
    assign denom_fault      = fault_reg;

`ifndef ASSERT_OFF
    // No word may enter while the derived constants are settling after a write.
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_write) |-> in_stall)
        else $error("input accepted right after a configuration write");

    // An unclamped zero-denominator result is full scale or zero.
    a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && denom_fault && !friction_limited) |->
        (yaw_rate == 24'sh7FFFFF || yaw_rate == 24'sh800000 || yaw_rate == 24'sh000000))
        else $error("zero denominator gave an unsaturated yaw rate");

    // The two dividers must stay in lockstep.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid == rdiv_valid)
        else $error("divider pipelines out of step");
`endif

endmodule
